// ===== src/rcc_pkg.sv =====
// -----------------------------------------------------------------------------
// Reverse camera controller package
// Shared widths, register map, reset values and the result record.
// -----------------------------------------------------------------------------
package rcc_pkg;

   // Width of the elapsed counters and of the tick registers.
   localparam int COUNT_WIDTH = 20;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // CSR bus
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   // Stream payload widths (fields padded to whole bytes)
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;

   // Register index, taken from csr_paddr[3:2]
   typedef enum logic [1:0] {
      REG_REVERSE_DEBOUNCE = 2'd0,
      REG_BUTTON_DEBOUNCE  = 2'd1,
      REG_AUTO_OFF         = 2'd2,
      REG_MANUAL_TIMEOUT   = 2'd3
   } reg_index_type;

   // Register reset values
   localparam logic [COUNT_WIDTH-1:0] RESET_REVERSE_DEBOUNCE = COUNT_WIDTH'(100);
   localparam logic [COUNT_WIDTH-1:0] RESET_BUTTON_DEBOUNCE  = COUNT_WIDTH'(200);
   localparam logic [COUNT_WIDTH-1:0] RESET_AUTO_OFF         = COUNT_WIDTH'(30000);
   localparam logic [COUNT_WIDTH-1:0] RESET_MANUAL_TIMEOUT   = COUNT_WIDTH'(60000);

   // One result record, first field in the highest bit
   typedef struct packed {
      logic held_by_button;
      logic held_by_reverse;
      logic reverse_changed;
      logic reverse_engaged;
      logic camera_on;
   } result_type;

   // Saturating one-tick advance
   function automatic logic [COUNT_WIDTH-1:0] sat_tick(input logic [COUNT_WIDTH-1:0] v);
      sat_tick = (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
   endfunction

endpackage

// ===== src/reverse_camera_controller_core.sv =====
// -----------------------------------------------------------------------------
// Reverse camera controller core
// Debounces reverse gear and a touch button once per tick transaction and
// drives the camera power switch with reverse, manual and auto-off timing.
// -----------------------------------------------------------------------------
// A result is registered (output or skid register) and driven on rsp_*.
// Throughput: one transaction per cycle while req_tready is high; the
//   single-pass tick update sits between the state and result registers.
// A two-entry output (result register plus skid register) keeps req_tready
//   high while one result waits; it drops only when both entries are full.
// Reset (synchronous, active high) loads the register defaults and the idle
//   state: samples high, reverse not engaged, camera off, counters zero.
module reverse_camera_controller_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // tick input: [0] reverse_level, [1] button_level, [7:2] zero
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rcc_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // result: [0] camera_on, [1] reverse_engaged, [2] reverse_changed,
   //         [3] held_by_reverse, [4] held_by_button, [7:5] zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rcc_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // APB-style register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rcc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [rcc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [rcc_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int CW = rcc_pkg::COUNT_WIDTH;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [CW-1:0] rev_debounce_ff, btn_debounce_ff, auto_off_ff, manual_timeout_ff;
   logic          csr_write;
   rcc_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = rcc_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_debounce_ff   <= rcc_pkg::RESET_REVERSE_DEBOUNCE;
         btn_debounce_ff   <= rcc_pkg::RESET_BUTTON_DEBOUNCE;
         auto_off_ff       <= rcc_pkg::RESET_AUTO_OFF;
         manual_timeout_ff <= rcc_pkg::RESET_MANUAL_TIMEOUT;
      end else if (csr_write) begin
         // only the low COUNT_WIDTH bits of the write data are kept
         case (csr_index)
            rcc_pkg::REG_REVERSE_DEBOUNCE: rev_debounce_ff   <= csr_pwdata[CW-1:0];
            rcc_pkg::REG_BUTTON_DEBOUNCE:  btn_debounce_ff   <= csr_pwdata[CW-1:0];
            rcc_pkg::REG_AUTO_OFF:         auto_off_ff       <= csr_pwdata[CW-1:0];
            rcc_pkg::REG_MANUAL_TIMEOUT:   manual_timeout_ff <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         rcc_pkg::REG_REVERSE_DEBOUNCE:
            csr_prdata = rcc_pkg::CSR_DATA_WIDTH'(rev_debounce_ff);
         rcc_pkg::REG_BUTTON_DEBOUNCE:
            csr_prdata = rcc_pkg::CSR_DATA_WIDTH'(btn_debounce_ff);
         rcc_pkg::REG_AUTO_OFF:
            csr_prdata = rcc_pkg::CSR_DATA_WIDTH'(auto_off_ff);
         rcc_pkg::REG_MANUAL_TIMEOUT:
            csr_prdata = rcc_pkg::CSR_DATA_WIDTH'(manual_timeout_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Tick state
   // ---------------------------------------------------------------------------
   logic          last_rev_ff,   last_rev_in;
   logic          stable_rev_ff, stable_rev_in;
   logic [CW-1:0] rev_since_ff,  rev_since_in;
   logic          last_btn_ff,   last_btn_in;
   logic [CW-1:0] btn_since_ff,  btn_since_in;
   logic          active_ff,     active_in;
   logic          mode_rev_ff,   mode_rev_in;
   logic          mode_btn_ff,   mode_btn_in;
   logic [CW-1:0] elapsed_ff,    elapsed_in;
   logic          changed;
   logic          rev_sample, btn_sample;
   logic          req_accept;
   rcc_pkg::result_type result;

   assign rev_sample = req_tdata[0];
   assign btn_sample = req_tdata[1];
   assign req_accept = req_tvalid && req_tready;

   // Single-pass update: advance counters, debounce reverse, check the
   // button, then apply the timeouts (on the advanced or restarted elapsed value).
   always_comb begin
      last_rev_in   = last_rev_ff;
      stable_rev_in = stable_rev_ff;
      rev_since_in  = rcc_pkg::sat_tick(rev_since_ff);
      btn_since_in  = rcc_pkg::sat_tick(btn_since_ff);
      elapsed_in    = rcc_pkg::sat_tick(elapsed_ff);
      active_in     = active_ff;
      mode_rev_in   = mode_rev_ff;
      mode_btn_in   = mode_btn_ff;
      changed       = 1'b0;

      // reverse debounce
      if (rev_sample != last_rev_ff) begin
         last_rev_in  = rev_sample;
         rev_since_in = '0;
      end else if (rev_sample != stable_rev_ff && rev_since_in >= rev_debounce_ff) begin
         stable_rev_in = rev_sample;
         changed       = 1'b1;
         if (!rev_sample) begin
            // engaged: camera on (or re-armed) in reverse mode
            active_in   = 1'b1;
            mode_rev_in = 1'b1;
            mode_btn_in = 1'b0;
            elapsed_in  = '0;
         end else if (mode_rev_ff) begin
            // released: auto-off countdown starts
            mode_rev_in = 1'b0;
            elapsed_in  = '0;
         end
         rev_since_in = '0;
      end

      // button start of an idle camera
      if (btn_sample != last_btn_ff)
         btn_since_in = '0;
      if (btn_since_in > btn_debounce_ff && btn_sample && !active_in) begin
         active_in   = 1'b1;
         mode_btn_in = 1'b1;
         mode_rev_in = 1'b0;
         elapsed_in  = '0;
      end

      // manual and auto-off timeouts
      if (active_in && ((mode_btn_in && elapsed_in >= manual_timeout_ff) ||
                        (!mode_rev_in && !mode_btn_in && elapsed_in >= auto_off_ff))) begin
         active_in   = 1'b0;
         mode_btn_in = 1'b0;
         mode_rev_in = 1'b0;
      end

      last_btn_in = btn_sample;

      result.camera_on       = active_in;
      result.reverse_engaged = !stable_rev_in;
      result.reverse_changed = changed;
      result.held_by_reverse = mode_rev_in;
      result.held_by_button  = mode_btn_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_rev_ff   <= 1'b1;
         stable_rev_ff <= 1'b1;
         rev_since_ff  <= '0;
         last_btn_ff   <= 1'b1;
         btn_since_ff  <= '0;
         active_ff     <= 1'b0;
         mode_rev_ff   <= 1'b0;
         mode_btn_ff   <= 1'b0;
         elapsed_ff    <= '0;
      end else if (req_accept) begin
         last_rev_ff   <= last_rev_in;
         stable_rev_ff <= stable_rev_in;
         rev_since_ff  <= rev_since_in;
         last_btn_ff   <= last_btn_in;
         btn_since_ff  <= btn_since_in;
         active_ff     <= active_in;
         mode_rev_ff   <= mode_rev_in;
         mode_btn_ff   <= mode_btn_in;
         elapsed_ff    <= elapsed_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Output register with skid entry
   // ---------------------------------------------------------------------------
   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   rcc_pkg::result_type out_data_ff, out_data_in;
   rcc_pkg::result_type skid_data_ff, skid_data_in;
   logic                rsp_pop;

   assign req_tready = !skid_valid_ff;
   assign rsp_pop    = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_pop) begin
         if (skid_valid_ff) begin
            // ready is low while skid is full, so no new transaction here
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (req_accept) begin
            out_data_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!out_valid_ff) begin
            out_data_in  = result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rcc_pkg::RSP_DATA_WIDTH'(out_data_ff);

endmodule
